// ===== hw/rtl/sacl_pkg.sv =====
// Shared types and constants for the set-associative cache LRU directory.
`default_nettype none

package sacl_pkg;

    localparam int ADDR_W      = 32;
    localparam int SETS        = 64;
    localparam int WAYS        = 4;
    localparam int BLOCK_BYTES = 32;

    localparam int OFS_W      = $clog2(BLOCK_BYTES);
    localparam int SET_W      = $clog2(SETS);
    localparam int TAG_W      = ADDR_W - OFS_W - SET_W;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W      = 8;
    localparam int CNT_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int WAY_USED_W = 2;

    localparam logic [CNT_W-1:0] MISS_PENALTY_RST = CNT_W'(50);
    localparam logic [AGE_W-1:0] AGE_MAX          = '1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SET_W-1:0]  t_set;
    typedef logic [TAG_W-1:0]  t_tag;
    typedef logic [WAY_W-1:0]  t_way;
    typedef logic [AGE_W-1:0]  t_age;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [STATUS_W-1:0] {
        ST_STALL  = 3'd0,
        ST_BUBBLE = 3'd1,
        ST_HIT    = 3'd2,
        ST_FILL   = 3'd3,
        ST_EVICT  = 3'd4
    } t_status;

    // One directory row: tag and age of every way of a set.
    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0] tag;
        logic [WAYS-1:0][AGE_W-1:0] age;
    } t_dir_row;

    typedef struct packed {
        t_status  status;
        t_way     way;
        logic     dir_we;
        logic     fill;
        t_dir_row dir_row;
        t_cnt     stall_next;
        logic     bubble_next;
    } t_lookup;

endpackage

`default_nettype wire

// ===== hw/rtl/sacl_if.sv =====
// Request, response and configuration channel interfaces.
`default_nettype none

interface sacl_req_if;
    import sacl_pkg::*;
    logic  valid;
    logic  ready;
    t_addr fetch_address;
    modport source (output valid, output fetch_address, input ready);
    modport sink (input valid, input fetch_address, output ready);
endinterface

interface sacl_rsp_if;
    import sacl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [WAY_USED_W-1:0] way_used;
    t_set                  set_index;
    t_addr                 line_address;
    modport source (output valid, output status, output way_used, output set_index,
                    output line_address, input ready);
    modport sink (input valid, input status, input way_used, input set_index,
                  input line_address, output ready);
endinterface

interface sacl_cfg_if;
    import sacl_pkg::*;
    logic valid;
    logic ready;
    t_cnt data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sacl_dir_ram.sv =====
// Directory RAM: one row of tags and ages per set, registered read with write forwarding.
`default_nettype none

module sacl_dir_ram (
    input  wire                i_clk,
    input  wire                i_rd_en,
    input  sacl_pkg::t_set     i_rd_set,
    input  wire                i_wr_en,
    input  sacl_pkg::t_set     i_wr_set,
    input  sacl_pkg::t_dir_row i_wr_row,
    output sacl_pkg::t_dir_row o_rd_row
);
    import sacl_pkg::*;

    t_dir_row r_mem [SETS];
    t_dir_row r_rd_row;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_set] <= i_wr_row;
        end
    end

    // A read of the row being written returns the new row.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_set == i_rd_set)) begin
                r_rd_row <= i_wr_row;
            end else begin
                r_rd_row <= r_mem[i_rd_set];
            end
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

`default_nettype wire

// ===== hw/rtl/sacl_lookup.sv =====
// Set lookup: hit search, fill or victim choice, age update and stall sequencing.
`default_nettype none

module sacl_lookup (
    input  sacl_pkg::t_tag     i_tag,
    input  sacl_pkg::t_dir_row i_row,
    input  wire [sacl_pkg::WAYS-1:0] i_valid,
    input  sacl_pkg::t_cnt     i_stall,
    input  wire                i_bubble,
    input  sacl_pkg::t_cnt     i_miss_penalty,
    output sacl_pkg::t_lookup  o_res
);
    import sacl_pkg::*;

    always_comb begin
        logic                   hit_found;
        logic                   free_found;
        t_way                   hit_way;
        t_way                   free_way;
        t_way                   sel_way;
        t_way                   fin_way;
        t_way                   victim;
        t_age                   best_age;
        t_status                st;
        logic [WAYS-1:0][AGE_W-1:0] eff_age;
        logic [WAYS-1:0][AGE_W-1:0] aged;

        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (i_valid[i]) begin
                if (!hit_found && (i_row.tag[i] == i_tag)) begin
                    hit_found = 1'b1;
                    hit_way   = t_way'(i);
                end
            end else if (!free_found) begin
                free_found = 1'b1;
                free_way   = t_way'(i);
            end
        end

        if (hit_found) begin
            st = ST_HIT;
        end else if (free_found) begin
            st = ST_FILL;
        end else begin
            st = ST_EVICT;
        end
        sel_way = hit_found ? hit_way : free_way;

        // Ways never filled still hold their reset age.
        for (int i = 0; i < WAYS; i++) begin
            eff_age[i] = i_valid[i] ? i_row.age[i] : AGE_W'(i);
            if (i_valid[i] && ((st == ST_EVICT) || (t_way'(i) != sel_way))
                && (eff_age[i] != AGE_MAX)) begin
                aged[i] = eff_age[i] + AGE_W'(1);
            end else begin
                aged[i] = eff_age[i];
            end
        end

        // Lowest way among the oldest.
        victim   = '0;
        best_age = aged[0];
        for (int i = 1; i < WAYS; i++) begin
            if (aged[i] > best_age) begin
                best_age = aged[i];
                victim   = t_way'(i);
            end
        end
        fin_way = (st == ST_EVICT) ? victim : sel_way;

        o_res = '0;
        for (int i = 0; i < WAYS; i++) begin
            o_res.dir_row.age[i] = (t_way'(i) == fin_way) ? '0 : aged[i];
            o_res.dir_row.tag[i] = ((t_way'(i) == fin_way) && !hit_found) ? i_tag
                                                                           : i_row.tag[i];
        end

        if (i_stall != '0) begin
            o_res.status      = ST_STALL;
            o_res.way         = '0;
            o_res.dir_we      = 1'b0;
            o_res.fill        = 1'b0;
            o_res.stall_next  = i_stall - CNT_W'(1);
            o_res.bubble_next = i_bubble;
        end else if (i_bubble) begin
            o_res.status      = ST_BUBBLE;
            o_res.way         = '0;
            o_res.dir_we      = 1'b0;
            o_res.fill        = 1'b0;
            o_res.stall_next  = '0;
            o_res.bubble_next = 1'b0;
        end else begin
            o_res.status      = st;
            o_res.way         = fin_way;
            o_res.dir_we      = 1'b1;
            o_res.fill        = !hit_found;
            o_res.stall_next  = hit_found ? '0 : i_miss_penalty;
            o_res.bubble_next = !hit_found;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/set_assoc_cache_lru_directory_core.sv =====
// Top level of the set-associative cache LRU directory.
// Usage:
//   i_req  : one fetch address per request (valid/ready).
//   o_rsp  : one response per request: status, way, set index and line address.
//   i_cfg  : writes the miss penalty (valid/ready, always ready); the user must write only while idle, not enforced.
// A request accepted at an edge reads its directory row at that edge; the lookup
// runs in the next cycle and its result is registered once the response register
// is free or taken. One request is taken every cycle unless the receiver stalls; the
// single-cycle rate is set by the directory RAM read/write per set, with the
// row being written forwarded to a read of the same set.
// After a miss, the next miss_penalty requests report stalled and the one after
// that reports the bubble.
// Reset clears all valid bits, the stall counter and the bubble flag at once and
// sets the miss penalty to 50; no clearing pass is needed and the block is ready
// as soon as reset is released.
// When the receiver stalls, the response register holds, the lookup stage holds
// behind it, and i_req.ready drops once both are full.
`default_nettype none

module set_assoc_cache_lru_directory_core (
    input wire        i_clk,
    input wire        i_rst_n,
    sacl_req_if.sink  i_req,
    sacl_rsp_if.source o_rsp,
    sacl_cfg_if.sink  i_cfg
);
    import sacl_pkg::*;

    logic                  w_adv;
    logic                  w_accept;
    logic                  w_fire;
    t_set                  w_in_set;
    t_set                  w_set1;
    t_tag                  w_tag1;
    t_dir_row              w_rd_row;
    t_lookup               w_lk;

    logic                  r_v1;
    t_addr                 r_addr1;
    logic [SETS-1:0][WAYS-1:0] r_valid;
    t_cnt                  r_stall;
    logic                  r_bubble;
    t_cnt                  r_miss_penalty;

    logic                  r_ov;
    t_status               r_status;
    t_way                  r_way;
    t_set                  r_set;
    t_addr                 r_line;

    assign w_adv    = !r_ov || o_rsp.ready;
    assign w_accept = i_req.valid && i_req.ready;
    assign w_fire   = r_v1 && w_adv;
    assign w_in_set = i_req.fetch_address[OFS_W +: SET_W];
    assign w_set1   = r_addr1[OFS_W +: SET_W];
    assign w_tag1   = r_addr1[ADDR_W-1 -: TAG_W];

    assign i_req.ready = !r_v1 || w_adv;
    assign i_cfg.ready = 1'b1;

    sacl_dir_ram u_dir_ram (
        .i_clk    (i_clk),
        .i_rd_en  (w_accept),
        .i_rd_set (w_in_set),
        .i_wr_en  (w_fire && w_lk.dir_we),
        .i_wr_set (w_set1),
        .i_wr_row (w_lk.dir_row),
        .o_rd_row (w_rd_row)
    );

    sacl_lookup u_lookup (
        .i_tag          (w_tag1),
        .i_row          (w_rd_row),
        .i_valid        (r_valid[w_set1]),
        .i_stall        (r_stall),
        .i_bubble       (r_bubble),
        .i_miss_penalty (r_miss_penalty),
        .o_res          (w_lk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_accept) begin
            r_v1 <= 1'b1;
        end else if (w_adv) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr1 <= i_req.fetch_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_stall  <= '0;
            r_bubble <= 1'b0;
        end else if (w_fire) begin
            r_stall  <= w_lk.stall_next;
            r_bubble <= w_lk.bubble_next;
            if (w_lk.fill) begin
                r_valid[w_set1][w_lk.way] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_penalty <= MISS_PENALTY_RST;
        end else if (i_cfg.valid) begin
            r_miss_penalty <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_fire) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= w_lk.status;
            r_way    <= w_lk.way;
            r_set    <= w_set1;
            r_line   <= {r_addr1[ADDR_W-1:OFS_W], OFS_W'(0)};
        end
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_status;
    assign o_rsp.way_used     = WAY_USED_W'(r_way);
    assign o_rsp.set_index    = r_set;
    assign o_rsp.line_address = r_line;

`ifndef SYNTH
    a_stall_has_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stall != '0) |-> r_bubble)
        else $error("stall count pending without bubble flag");

    a_miss_sets_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && ((w_lk.status == ST_FILL) || (w_lk.status == ST_EVICT))) |=> r_bubble)
        else $error("miss did not arm the bubble");

    a_fill_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_lk.fill) |=> r_valid[$past(w_set1)][$past(w_lk.way)])
        else $error("filled way not marked valid");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_ov && !o_rsp.ready) |=> (r_v1 && $stable(r_addr1)))
        else $error("lookup stage lost its request under backpressure");
`endif

endmodule

`default_nettype wire

// ===== verif/set_assoc_cache_lru_directory_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the set-associative cache LRU directory core.

module set_assoc_cache_lru_directory_core_tb;
    import sacl_pkg::*;

    typedef struct {
        t_status               status;
        logic [WAY_USED_W-1:0] way;
        t_set                  set_index;
        t_addr                 line_address;
    } fetch_result_t;

    logic clk;
    logic rst_n;

    sacl_req_if req_if();
    sacl_rsp_if rsp_if();
    sacl_cfg_if cfg_if();

    set_assoc_cache_lru_directory_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // Directory mirror
    t_tag line_tag   [SETS][WAYS];
    bit   line_valid [SETS][WAYS];
    t_age line_age   [SETS][WAYS];
    t_cnt stall_left;
    bit   bubble_due;
    t_cnt miss_penalty_q;

    fetch_result_t awaited_results[$];
    int            fail_count;

    int   source_idle_pct;
    int   sink_stall_pct;
    int   sink_hold;
    t_tag tag_pool[6];

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #6_000_000;
        $display("set_assoc_cache_lru_directory_core: mismatch");
        $finish;
    end

    function automatic t_addr make_addr(input t_tag tg, input t_set s, input logic [31:0] ofs);
        return {tg, s, ofs[OFS_W-1:0]};
    endfunction

    // Advances the directory mirror by one request and returns its response.
    function automatic fetch_result_t lookup_directory(input t_addr a);
        fetch_result_t r;
        t_set          s;
        t_tag          tg;
        int            hit_way;
        int            free_way;
        int            way_sel;
        s        = a[OFS_W +: SET_W];
        tg       = a[ADDR_W-1 -: TAG_W];
        hit_way  = -1;
        free_way = -1;
        way_sel  = 0;
        r.set_index    = s;
        r.line_address = {a[ADDR_W-1:OFS_W], {OFS_W{1'b0}}};
        if (stall_left != 0) begin
            stall_left--;
            r.status = ST_STALL;
        end else if (bubble_due) begin
            bubble_due = 1'b0;
            r.status   = ST_BUBBLE;
        end else begin
            for (int w = 0; w < WAYS; w++) begin
                if (line_valid[s][w]) begin
                    if (hit_way < 0 && line_tag[s][w] == tg) hit_way = w;
                end else if (free_way < 0) begin
                    free_way = w;
                end
            end
            if (hit_way >= 0) begin
                r.status = ST_HIT;
                way_sel  = hit_way;
            end else if (free_way >= 0) begin
                r.status = ST_FILL;
                way_sel  = free_way;
            end else begin
                r.status = ST_EVICT;
            end
            for (int w = 0; w < WAYS; w++) begin
                if (line_valid[s][w] && (r.status == ST_EVICT || w != way_sel) &&
                    line_age[s][w] != AGE_MAX)
                    line_age[s][w]++;
            end
            // lowest way wins a tie on age
            if (r.status == ST_EVICT) begin
                for (int w = 1; w < WAYS; w++)
                    if (line_age[s][w] > line_age[s][way_sel]) way_sel = w;
            end
            line_age[s][way_sel] = '0;
            if (r.status != ST_HIT) begin
                line_valid[s][way_sel] = 1'b1;
                line_tag[s][way_sel]   = tg;
                stall_left             = miss_penalty_q;
                bubble_due             = 1'b1;
            end
        end
        r.way = WAY_USED_W'(way_sel);
        return r;
    endfunction

    function automatic int source_gap();
        if ($urandom_range(0, 99) >= source_idle_pct) return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    endfunction

    function automatic t_addr rand_fetch();
        t_set s;
        if ($urandom_range(0, 99) < 15) return t_addr'($urandom);
        s = ($urandom_range(0, 3) == 0) ? t_set'($urandom) : t_set'($urandom_range(0, 2));
        return make_addr(tag_pool[$urandom_range(0, 5)], s, $urandom);
    endfunction

    // Called and returns at a falling edge.
    task automatic send_fetch(input t_addr a);
        int gap;
        gap = source_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.fetch_address <= a;
        do @(posedge clk); while (!req_if.ready);
        awaited_results.push_back(lookup_directory(a));
        @(negedge clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_penalty(input t_cnt v);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge clk); while (!cfg_if.ready);
        miss_penalty_q = v;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic refill_tag_pool();
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < 6; i++) tag_pool[i] = t_tag'($urandom);
    endtask

    // Response sink: random backpressure, short stalls mostly, a few long ones.
    initial begin
        rsp_if.ready = 1'b0;
        sink_hold    = 0;
        forever begin
            @(negedge clk);
            if (sink_hold > 0) begin
                sink_hold--;
                rsp_if.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < sink_stall_pct) begin
                sink_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                        : $urandom_range(0, 2);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        fetch_result_t exp_r;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (awaited_results.size() == 0) begin
                $error("response with no request outstanding: status %0d set %0d",
                       rsp_if.status, rsp_if.set_index);
                fail_count++;
            end else begin
                exp_r = awaited_results.pop_front();
                if (rsp_if.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, rsp_if.status);
                    fail_count++;
                end
                if (rsp_if.way_used !== exp_r.way) begin
                    $error("way_used: expected %0d, got %0d", exp_r.way, rsp_if.way_used);
                    fail_count++;
                end
                if (rsp_if.set_index !== exp_r.set_index) begin
                    $error("set_index: expected %0d, got %0d",
                           exp_r.set_index, rsp_if.set_index);
                    fail_count++;
                end
                if (rsp_if.line_address !== exp_r.line_address) begin
                    $error("line_address: expected %h, got %h",
                           exp_r.line_address, rsp_if.line_address);
                    fail_count++;
                end
            end
        end
    end

    // Miss at the power-up penalty: full stall run, bubble, then a hit.
    task automatic test_reset_penalty();
        source_idle_pct = 20;
        sink_stall_pct  = 20;
        send_fetch(32'hA5A5_A5A5);
        repeat (int'(MISS_PENALTY_RST) + 1) send_fetch(t_addr'($urandom));
        send_fetch(32'hA5A5_A5BF);
    endtask

    task automatic test_directed();
        source_idle_pct = 0;
        sink_stall_pct  = 0;
        write_penalty('0);
        send_fetch(32'h0000_0000);
        send_fetch(32'hFFFF_FFFF);
        send_fetch(32'h0000_001F);
        send_fetch(32'hFFFF_FFFF);
        send_fetch(32'h1234_5678);
        send_fetch(32'hFFFF_FFE0);
        // fill every way of set 1, then force an eviction
        for (int t = 1; t <= WAYS; t++) begin
            send_fetch(make_addr(t_tag'(t), t_set'(1), $urandom));
            send_fetch(t_addr'($urandom));
        end
        send_fetch(make_addr(t_tag'(1), t_set'(1), 0));
        send_fetch(make_addr(t_tag'(5), t_set'(1), 31));
        send_fetch(32'h0000_0000);
        send_fetch(make_addr(t_tag'(1), t_set'(1), 7));
        send_fetch(make_addr(t_tag'(2), t_set'(1), 7));
    endtask

    // Ways 2 and 3 of one set age to the ceiling while 0 and 1 keep hitting.
    task automatic test_age_saturation();
        source_idle_pct = 10;
        sink_stall_pct  = 10;
        write_penalty('0);
        for (int w = 0; w < WAYS; w++) begin
            send_fetch(make_addr(t_tag'(21'h100 + w), t_set'(10), $urandom));
            send_fetch(t_addr'($urandom));
        end
        repeat (300)
            send_fetch(make_addr(t_tag'(21'h100 + $urandom_range(0, 1)), t_set'(10), $urandom));
        send_fetch(make_addr('1, t_set'(10), 0));
        send_fetch(t_addr'($urandom));
        send_fetch(make_addr(t_tag'(21'h103), t_set'(10), 0));
        send_fetch(make_addr('1, t_set'(10), 4));
    endtask

    task automatic test_max_penalty();
        source_idle_pct = 15;
        sink_stall_pct  = 15;
        write_penalty('1);
        send_fetch(make_addr(t_tag'($urandom), t_set'(20), $urandom));
        repeat (256) send_fetch(t_addr'($urandom));
        refill_tag_pool();
        repeat (8) send_fetch(rand_fetch());
    endtask

    task automatic test_random_traffic();
        t_cnt penalties[4];
        int   idle_mix[4];
        penalties[0] = t_cnt'(1);
        penalties[1] = t_cnt'($urandom_range(2, 6));
        penalties[2] = '0;
        penalties[3] = t_cnt'($urandom_range(0, 3));
        idle_mix[0]  = 30;
        idle_mix[1]  = 0;
        idle_mix[2]  = 60;
        idle_mix[3]  = 15;
        for (int p = 0; p < 4; p++) begin
            write_penalty(penalties[p]);
            refill_tag_pool();
            source_idle_pct = idle_mix[p];
            sink_stall_pct  = idle_mix[(p + 1) % 4];
            repeat (250) send_fetch(rand_fetch());
        end
    endtask

    initial begin
        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.fetch_address = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.data          = '0;
        fail_count           = 0;
        source_idle_pct      = 0;
        sink_stall_pct       = 0;
        stall_left           = '0;
        bubble_due           = 1'b0;
        miss_penalty_q       = MISS_PENALTY_RST;
        for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
                line_tag[s][w]   = '0;
                line_valid[s][w] = 1'b0;
                line_age[s][w]   = t_age'(w);
            end
        end
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_penalty();
        test_directed();
        test_age_saturation();
        test_max_penalty();
        test_random_traffic();

        drain();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("set_assoc_cache_lru_directory_core: match");
        else
            $display("set_assoc_cache_lru_directory_core: mismatch");
        $finish;
    end

endmodule
